// ===== sv/wps_pkg.sv =====
// Shared types, phase codes and status codes of the WAV PCM16 stream parser.
package wps_pkg;

	localparam logic [3:0] PH_RIFF  = 4'd0;
	localparam logic [3:0] PH_RSIZE = 4'd1;
	localparam logic [3:0] PH_WAVE  = 4'd2;
	localparam logic [3:0] PH_HDR   = 4'd3;
	localparam logic [3:0] PH_SKIP  = 4'd4;
	localparam logic [3:0] PH_FMT   = 4'd5;
	localparam logic [3:0] PH_PAD   = 4'd6;
	localparam logic [3:0] PH_DATA  = 4'd7;
	localparam logic [3:0] PH_DRAIN = 4'd8;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [2:0] ST_FRAME     = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_NOT_RIFF  = 3'd2;
	localparam logic [2:0] ST_NOT_PCM   = 3'd3;
	localparam logic [2:0] ST_NOT_16BIT = 3'd4;
	localparam logic [2:0] ST_BAD_CHAN  = 3'd5;
	localparam logic [2:0] ST_TRUNC     = 3'd6;

	localparam logic [15:0] GAIN_RESET = 16'd2048;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
		logic [2:0]  status;
		logic        last_frame;
		logic [31:0] rate_hz;
		logic [15:0] channel_count;
	} wps_res_t;

endpackage

// ===== sv/wps_gain.sv =====
// Q4.12 gain stage: signed sample times unsigned gain, truncated toward zero and saturated.
module wps_gain (
	input  logic [15:0] sample,
	input  logic [15:0] gain,
	output logic [15:0] scaled
);

	logic signed [32:0] prod;
	logic signed [32:0] biased;
	logic signed [20:0] quot;

	always_comb begin
		prod   = $signed({{17{sample[15]}}, sample}) * $signed({17'd0, gain});
		biased = prod + (prod[32] ? 33'sd4095 : 33'sd0);
		quot   = biased[32:12];
		if (quot > 21'sd32767) begin
			scaled = 16'h7FFF;
		end else if (quot < -21'sd32768) begin
			scaled = 16'h8000;
		end else begin
			scaled = quot[15:0];
		end
	end

endmodule

// ===== sv/wps_parser.sv =====
// Byte-level RIFF/WAVE chunk walker that captures the format and assembles raw frames.
module wps_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_acc,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	output logic              res_fire,
	output wps_pkg::wps_res_t res
);

	logic [3:0]  phase_q, phase_d;
	logic [31:0] cnt_q, cnt_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] len_q, len_d;
	logic [15:0] fmt_q, fmt_d;
	logic [15:0] chan_q, chan_d;
	logic [31:0] rate_q, rate_d;
	logic [15:0] bits_q, bits_d;
	logic        fv_q, fv_d;
	logic [23:0] asm_q, asm_d;
	logic [1:0]  fbi_q, fbi_d;

	logic [31:0] cnt_inc;
	logic [31:0] usable;
	logic        mono;
	logic        done;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		tag_d   = tag_q;
		len_d   = len_q;
		fmt_d   = fmt_q;
		chan_d  = chan_q;
		rate_d  = rate_q;
		bits_d  = bits_q;
		fv_d    = fv_q;
		asm_d   = asm_q;
		fbi_d   = fbi_q;
		res_fire         = 1'b0;
		res.left         = 16'd0;
		res.right        = 16'd0;
		res.status       = wps_pkg::ST_FRAME;
		res.last_frame   = 1'b0;
		cnt_inc = cnt_q + 32'd1;
		mono    = (chan_q == 16'd1);
		usable  = mono ? {len_q[31:1], 1'b0} : {len_q[31:2], 2'b00};
		done    = 1'b0;

		case (phase_q)
			wps_pkg::PH_RIFF, wps_pkg::PH_WAVE: begin
				tag_d = {tag_q[23:0], in_byte};
				cnt_d = cnt_inc;
				if (cnt_inc >= 32'd4) begin
					if (tag_d != ((phase_q == wps_pkg::PH_RIFF) ? wps_pkg::TAG_RIFF
						: wps_pkg::TAG_WAVE)) begin
						res_fire   = 1'b1;
						res.status = wps_pkg::ST_NOT_RIFF;
						phase_d    = wps_pkg::PH_DRAIN;
					end else begin
						phase_d = (phase_q == wps_pkg::PH_RIFF) ? wps_pkg::PH_RSIZE
							: wps_pkg::PH_HDR;
						len_d   = 32'd0;
					end
					cnt_d = 32'd0;
				end
			end
			wps_pkg::PH_RSIZE: begin
				cnt_d = cnt_inc;
				if (cnt_inc >= 32'd4) begin
					phase_d = wps_pkg::PH_WAVE;
					cnt_d   = 32'd0;
				end
			end
			wps_pkg::PH_HDR: begin
				if (cnt_q < 32'd4) begin
					tag_d = {tag_q[23:0], in_byte};
				end else begin
					case (cnt_q[1:0])
						2'd0:    len_d[7:0]   = in_byte;
						2'd1:    len_d[15:8]  = in_byte;
						2'd2:    len_d[23:16] = in_byte;
						default: len_d[31:24] = in_byte;
					endcase
				end
				cnt_d = cnt_inc;
				if (cnt_inc >= 32'd8) begin
					cnt_d = 32'd0;
					if (tag_d == wps_pkg::TAG_DATA) begin
						if (!fv_q || fmt_q != 16'd1) begin
							res_fire   = 1'b1;
							res.status = wps_pkg::ST_NOT_PCM;
							phase_d    = wps_pkg::PH_DRAIN;
						end else if (bits_q != 16'd16) begin
							res_fire   = 1'b1;
							res.status = wps_pkg::ST_NOT_16BIT;
							phase_d    = wps_pkg::PH_DRAIN;
						end else if (chan_q != 16'd1 && chan_q != 16'd2) begin
							res_fire   = 1'b1;
							res.status = wps_pkg::ST_BAD_CHAN;
							phase_d    = wps_pkg::PH_DRAIN;
						end else if (len_d < (mono ? 32'd2 : 32'd4)) begin
							res_fire   = 1'b1;
							res.status = wps_pkg::ST_EMPTY;
							phase_d    = wps_pkg::PH_DRAIN;
						end else begin
							phase_d = wps_pkg::PH_DATA;
							fbi_d   = 2'd0;
							asm_d   = 24'd0;
						end
					end else if (tag_d == wps_pkg::TAG_FMT && len_d >= 32'd16) begin
						phase_d = wps_pkg::PH_FMT;
					end else if (len_d == 32'd0) begin
						phase_d = wps_pkg::PH_HDR;
					end else begin
						phase_d = wps_pkg::PH_SKIP;
					end
				end
			end
			wps_pkg::PH_FMT: begin
				if (cnt_q[31:4] == 28'd0) begin
					case (cnt_q[3:0])
						4'd0:  fmt_d[7:0]    = in_byte;
						4'd1:  fmt_d[15:8]   = in_byte;
						4'd2:  chan_d[7:0]   = in_byte;
						4'd3:  chan_d[15:8]  = in_byte;
						4'd4:  rate_d[7:0]   = in_byte;
						4'd5:  rate_d[15:8]  = in_byte;
						4'd6:  rate_d[23:16] = in_byte;
						4'd7:  rate_d[31:24] = in_byte;
						4'd14: bits_d[7:0]   = in_byte;
						4'd15: begin
							bits_d[15:8] = in_byte;
							fv_d         = 1'b1;
						end
						default: ;
					endcase
				end
				cnt_d = cnt_inc;
				done  = (cnt_inc >= len_q);
			end
			wps_pkg::PH_SKIP: begin
				cnt_d = cnt_inc;
				done  = (cnt_inc >= len_q);
			end
			wps_pkg::PH_PAD: begin
				phase_d = wps_pkg::PH_HDR;
				cnt_d   = 32'd0;
				len_d   = 32'd0;
			end
			wps_pkg::PH_DATA: begin
				case (fbi_q)
					2'd0:    asm_d[7:0]   = in_byte;
					2'd1:    asm_d[15:8]  = in_byte;
					2'd2:    asm_d[23:16] = in_byte;
					default: ;
				endcase
				fbi_d = fbi_q + 2'd1;
				cnt_d = cnt_inc;
				if (fbi_q == 2'd3 || (mono && fbi_q == 2'd1)) begin
					res_fire       = 1'b1;
					res.left       = mono ? {in_byte, asm_q[7:0]} : asm_q[15:0];
					res.right      = mono ? {in_byte, asm_q[7:0]} : {in_byte, asm_q[23:16]};
					res.last_frame = (cnt_inc >= usable);
					fbi_d          = 2'd0;
					if (cnt_inc >= usable) begin
						phase_d = wps_pkg::PH_DRAIN;
						cnt_d   = 32'd0;
					end
				end
			end
			default: ;
		endcase

		if (done) begin
			phase_d = len_q[0] ? wps_pkg::PH_PAD : wps_pkg::PH_HDR;
			cnt_d   = 32'd0;
		end

		res.rate_hz       = rate_d;
		res.channel_count = chan_d;

		if (in_last) begin
			if (phase_d != wps_pkg::PH_DRAIN) begin
				res_fire       = 1'b1;
				res.status     = wps_pkg::ST_TRUNC;
				res.left       = 16'd0;
				res.right      = 16'd0;
				res.last_frame = 1'b0;
			end
			phase_d = wps_pkg::PH_RIFF;
			cnt_d   = 32'd0;
			tag_d   = 32'd0;
			len_d   = 32'd0;
			fmt_d   = 16'd0;
			chan_d  = 16'd0;
			rate_d  = 32'd0;
			bits_d  = 16'd0;
			fv_d    = 1'b0;
			asm_d   = 24'd0;
			fbi_d   = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wps_pkg::PH_RIFF;
			cnt_q   <= 32'd0;
			tag_q   <= 32'd0;
			len_q   <= 32'd0;
			fmt_q   <= 16'd0;
			chan_q  <= 16'd0;
			rate_q  <= 32'd0;
			bits_q  <= 16'd0;
			fv_q    <= 1'b0;
			asm_q   <= 24'd0;
			fbi_q   <= 2'd0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			tag_q   <= tag_d;
			len_q   <= len_d;
			fmt_q   <= fmt_d;
			chan_q  <= chan_d;
			rate_q  <= rate_d;
			bits_q  <= bits_d;
			fv_q    <= fv_d;
			asm_q   <= asm_d;
			fbi_q   <= fbi_d;
		end
	end

	// A partial frame can only exist while sample data is being collected.
	a_fbi_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != wps_pkg::PH_DATA |-> fbi_q == 2'd0)
		else $error("frame byte index set outside the data chunk");

endmodule

// ===== sv/wps_top_placeholder_unused.sv =====
// Stream skid-free output register helper that holds one result word for the receiver.
module wps_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              take,
	input  wps_pkg::wps_res_t din,
	output logic              vld,
	output wps_pkg::wps_res_t dout
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= 1'b0;
		end else if (take || !vld) begin
			vld <= load;
		end
	end

	always_ff @(posedge clk) begin
		if ((take || !vld) && load) begin
			dout <= din;
		end
	end

endmodule

// ===== sv/wav_pcm16_stream_parser.sv =====
// Top level of the WAV PCM16 stream parser with Q4.12 gain.
//
// The slave channel takes one word per file byte: s_tdata holds the byte and s_tlast
// marks the final byte of the file. The master channel gives one word per result:
// a stereo frame (mono is copied to both sides) or a status code in m_tuser, with
// m_tlast on the final frame of the data chunk. Frames are emitted as they arrive;
// a file that ends before its data chunk is complete gives a truncation status at
// its last byte, and the parser then waits for a new RIFF header.
// The gain register is written through cfg_we and cfg_wdata; the user must do this only
// while the block is idle, as the block does not enforce it. A byte is taken every cycle
// while s_tready is high. A result is registered first in the middle stage after the
// chunk walker and frame assembly, then in the output register after the gain multiply
// and saturation. Reset clears the parser state, both stages and sets the gain to one half.
// When the receiver stalls, the output register holds its word, the middle stage
// can still take one more result, and s_tready drops only once both are full.
module wav_pcm16_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // Bits 7:0 wav_byte.
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // Bits 15:0 left, 31:16 right, 63:32 rate_hz, 79:64 channels.
	output logic [2:0]  m_tuser,   // Bits 2:0 status.
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic              s_acc;
	logic              ready_s2;
	logic              res_fire;
	wps_pkg::wps_res_t res;
	logic              vld_s1;
	wps_pkg::wps_res_t res_s1;
	wps_pkg::wps_res_t scl_s1;
	wps_pkg::wps_res_t res_s2;
	logic [15:0]       gain_q;

	assign ready_s2 = !m_tvalid || m_tready;
	assign s_tready = !vld_s1 || ready_s2;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= wps_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	wps_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (s_acc),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.res_fire (res_fire),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_acc && res_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && res_fire) begin
			res_s1 <= res;
		end
	end

	wps_gain u_gain_l (
		.sample (res_s1.left),
		.gain   (gain_q),
		.scaled (scl_s1.left)
	);

	wps_gain u_gain_r (
		.sample (res_s1.right),
		.gain   (gain_q),
		.scaled (scl_s1.right)
	);

	assign scl_s1.status        = res_s1.status;
	assign scl_s1.last_frame    = res_s1.last_frame;
	assign scl_s1.rate_hz       = res_s1.rate_hz;
	assign scl_s1.channel_count = res_s1.channel_count;

	wps_outreg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (vld_s1),
		.take   (m_tready),
		.din    (scl_s1),
		.vld    (m_tvalid),
		.dout   (res_s2)
	);

	assign m_tdata = {res_s2.channel_count, res_s2.rate_hz, res_s2.right, res_s2.left};
	assign m_tuser = res_s2.status;
	assign m_tlast = res_s2.last_frame;

	// Status words carry no audio and never end a frame sequence.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != wps_pkg::ST_FRAME |-> m_tdata[31:0] == 32'd0 && !m_tlast)
		else $error("status word carries sample data or a frame end mark");

	// Mono frames must present the same sample on both sides.
	a_mono_copy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == wps_pkg::ST_FRAME && m_tdata[79:64] == 16'd1
		|-> m_tdata[15:0] == m_tdata[31:16])
		else $error("mono frame with differing left and right samples");

	// A result held in the middle stage must not be lost while the output stalls.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !ready_s2 |=> vld_s1 && $stable(res_s1))
		else $error("middle stage result dropped or changed during a stall");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the WAV PCM16 stream parser with Q4.12 gain.
`timescale 1ns / 1ps

module tb_top;

	localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} wav_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;   // Bits 15:0 left, 31:16 right, 63:32 rate_hz, 79:64 channels.
	logic [2:0]  m_tuser;   // Bits 2:0 status.
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	wav_pcm16_stream_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	wav_byte_t          byte_q[$];
	logic [7:0]         file_q[$];
	wps_pkg::wps_res_t  frame_q[$];
	int          bytes_queued = 0;
	int          mismatches = 0;
	int          gap_left = 0;
	int          rx_wait = 0;
	int          hold_left = 0;
	int          hold_ticket = 0;
	int          hold_seen = 0;
	int          idle_cycles = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;

	// Parser state as the block should hold it.
	logic [15:0] gain_q = wps_pkg::GAIN_RESET;
	logic [3:0]  parse_phase = wps_pkg::PH_RIFF;
	logic [31:0] pos = '0;
	logic [31:0] tag = '0;
	logic [31:0] chunk_len = '0;
	logic [15:0] fmt_code = '0;
	logic [15:0] chans_seen = '0;
	logic [31:0] rate_seen = '0;
	logic [15:0] bits_seen = '0;
	logic        fmt_ok = 1'b0;
	logic [31:0] sample_buf = '0;
	logic [31:0] frame_idx = '0;

	function automatic logic [15:0] apply_gain(input logic [15:0] raw);
		longint prod;
		prod = longint'($signed(raw)) * longint'(gain_q);
		prod = prod / 4096;
		if (prod > 32767)
			prod = 32767;
		else if (prod < -32768)
			prod = -32768;
		return prod[15:0];
	endfunction

	function automatic wps_pkg::wps_res_t fail_word(input logic [2:0] st);
		wps_pkg::wps_res_t w;
		w = '0;
		w.status = st;
		w.rate_hz = rate_seen;
		w.channel_count = chans_seen;
		parse_phase = wps_pkg::PH_DRAIN;
		pos = '0;
		return w;
	endfunction

	function automatic void close_chunk();
		parse_phase = chunk_len[0] ? wps_pkg::PH_PAD : wps_pkg::PH_HDR;
		pos = '0;
	endfunction

	// Advances the parser by one file byte; returns 1 when the byte yields an output word.
	function automatic bit parse_byte(input logic [7:0] b, input logic eof,
			output wps_pkg::wps_res_t word);
		bit emit;
		logic [31:0] fs;
		logic [31:0] usable;
		emit = 1'b0;
		word = '0;
		case (parse_phase)
			wps_pkg::PH_RIFF, wps_pkg::PH_WAVE: begin
				tag = {tag[23:0], b};
				pos++;
				if (pos >= 4) begin
					if (tag != ((parse_phase == wps_pkg::PH_RIFF) ? wps_pkg::TAG_RIFF
						: wps_pkg::TAG_WAVE)) begin
						word = fail_word(wps_pkg::ST_NOT_RIFF);
						emit = 1'b1;
					end else begin
						parse_phase = (parse_phase == wps_pkg::PH_RIFF) ? wps_pkg::PH_RSIZE
							: wps_pkg::PH_HDR;
						pos = '0;
						chunk_len = '0;
					end
				end
			end
			wps_pkg::PH_RSIZE: begin
				pos++;
				if (pos >= 4) begin
					parse_phase = wps_pkg::PH_WAVE;
					pos = '0;
				end
			end
			wps_pkg::PH_HDR: begin
				if (pos < 4)
					tag = {tag[23:0], b};
				else
					chunk_len[8 * (pos - 4) +: 8] = b;
				pos++;
				if (pos >= 8) begin
					pos = '0;
					if (tag == wps_pkg::TAG_DATA) begin
						emit = 1'b1;
						if (!fmt_ok || fmt_code != 16'd1)
							word = fail_word(wps_pkg::ST_NOT_PCM);
						else if (bits_seen != 16'd16)
							word = fail_word(wps_pkg::ST_NOT_16BIT);
						else if (chans_seen != 16'd1 && chans_seen != 16'd2)
							word = fail_word(wps_pkg::ST_BAD_CHAN);
						else if (chunk_len < 32'(chans_seen) * 2)
							word = fail_word(wps_pkg::ST_EMPTY);
						else begin
							emit = 1'b0;
							parse_phase = wps_pkg::PH_DATA;
							frame_idx = '0;
							sample_buf = '0;
						end
					end else if (tag == wps_pkg::TAG_FMT && chunk_len >= 16)
						parse_phase = wps_pkg::PH_FMT;
					else if (chunk_len == 0)
						parse_phase = wps_pkg::PH_HDR;
					else
						parse_phase = wps_pkg::PH_SKIP;
				end
			end
			wps_pkg::PH_FMT: begin
				case (pos)
					0, 1: fmt_code[8 * pos +: 8] = b;
					2, 3: chans_seen[8 * (pos - 2) +: 8] = b;
					4, 5, 6, 7: rate_seen[8 * (pos - 4) +: 8] = b;
					14: bits_seen[7:0] = b;
					15: begin
						bits_seen[15:8] = b;
						fmt_ok = 1'b1;
					end
					default: ;
				endcase
				pos++;
				if (pos >= chunk_len)
					close_chunk();
			end
			wps_pkg::PH_SKIP: begin
				pos++;
				if (pos >= chunk_len)
					close_chunk();
			end
			wps_pkg::PH_PAD: begin
				parse_phase = wps_pkg::PH_HDR;
				pos = '0;
				chunk_len = '0;
			end
			wps_pkg::PH_DATA: begin
				fs = (chans_seen == 16'd1) ? 32'd2 : 32'd4;
				usable = (chunk_len / fs) * fs;
				sample_buf[8 * frame_idx +: 8] = b;
				frame_idx++;
				pos++;
				if (frame_idx == fs) begin
					word.left = apply_gain(sample_buf[15:0]);
					word.right = (fs == 4) ? apply_gain(sample_buf[31:16]) : word.left;
					word.status = wps_pkg::ST_FRAME;
					word.last_frame = (pos >= usable);
					word.rate_hz = rate_seen;
					word.channel_count = chans_seen;
					emit = 1'b1;
					frame_idx = '0;
					if (word.last_frame) begin
						parse_phase = wps_pkg::PH_DRAIN;
						pos = '0;
					end
				end
			end
			default: ;
		endcase
		if (eof) begin
			if (parse_phase != wps_pkg::PH_DRAIN) begin
				word = fail_word(wps_pkg::ST_TRUNC);
				emit = 1'b1;
			end
			parse_phase = wps_pkg::PH_RIFF;
			pos = '0;
			tag = '0;
			chunk_len = '0;
			fmt_code = '0;
			chans_seen = '0;
			rate_seen = '0;
			bits_seen = '0;
			fmt_ok = 1'b0;
			sample_buf = '0;
			frame_idx = '0;
		end
		return emit;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < 50)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Sender: one byte per word, with a random gap before each while tx_idle_on is set.
	always @(posedge clk) begin : drive_proc
		logic nv;
		wps_pkg::wps_res_t word;
		wav_byte_t it;
		nv = s_tvalid;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (parse_byte(s_tdata, s_tlast, word))
					frame_q.push_back(word);
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0)
					gap_left--;
				else if (byte_q.size() != 0) begin
					it = byte_q.pop_front();
					s_tdata <= it.data;
					s_tlast <= it.last;
					nv = 1'b1;
					gap_left = tx_idle_on ? $urandom_range(0, 14) : 0;
				end
			end
		end
		s_tvalid <= nv;
	end

	// Receiver: a random stall after each word while rx_idle_on is set, and a long hold when requested.
	always @(posedge clk) begin : sink_proc
		int w;
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_ticket != hold_seen) begin
			hold_seen <= hold_ticket;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= (hold_left == 1);
		end else if (m_tvalid && m_tready) begin
			w = rx_idle_on ? $urandom_range(0, 14) : 0;
			rx_wait <= w;
			m_tready <= (w == 0);
		end else if (rx_wait != 0) begin
			rx_wait <= rx_wait - 1;
			m_tready <= (rx_wait == 1);
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin : check_proc
		wps_pkg::wps_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_q.size() == 0) begin
				if (mismatches < 50)
					$display("%0t: unexpected word, expected none, actual %h status %0d",
						$time, m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = frame_q.pop_front();
				check_field("left", 32'(want.left), 32'(m_tdata[15:0]));
				check_field("right", 32'(want.right), 32'(m_tdata[31:16]));
				check_field("rate_hz", want.rate_hz, m_tdata[63:32]);
				check_field("channels", 32'(want.channel_count), 32'(m_tdata[79:64]));
				check_field("status", 32'(want.status), 32'(m_tuser));
				check_field("last_frame", 32'(want.last_frame), 32'(m_tlast));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic put_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(v[8 * i +: 8]);
	endtask

	task automatic put_tag(input logic [31:0] t);
		put_le({t[7:0], t[15:8], t[23:16], t[31:24]}, 4);
	endtask

	task automatic put_data(input int n);
		logic [15:0] s;
		for (int i = 0; i < n; i += 2) begin
			case ($urandom_range(0, 5))
				0: s = 16'h8000;
				1: s = 16'h7FFF;
				2: s = 16'hFFFF;
				3: s = 16'h0000;
				default: s = 16'($urandom);
			endcase
			file_q.push_back(s[7:0]);
			if (i + 1 < n)
				file_q.push_back(s[15:8]);
		end
	endtask

	task automatic put_junk();
		int len;
		len = $urandom_range(0, 7);
		put_tag($urandom_range(0, 1) ? TAG_LIST : 32'($urandom));
		put_le(len, 4);
		repeat (len) file_q.push_back(8'($urandom));
		if (len % 2)
			file_q.push_back(8'h00);
	endtask

	task automatic put_fmt(input logic [15:0] fc, input logic [15:0] chans,
			input logic [15:0] bps, input int flen);
		put_tag(wps_pkg::TAG_FMT);
		put_le(flen, 4);
		if (flen >= 16) begin
			put_le(32'(fc), 2);
			put_le(32'(chans), 2);
			put_le($urandom, 4);
			put_le($urandom, 4);
			put_le(32'(chans) * 32'd2, 2);
			put_le(32'(bps), 2);
			repeat (flen - 16) file_q.push_back(8'($urandom));
		end else
			repeat (flen) file_q.push_back(8'($urandom));
		if (flen % 2)
			file_q.push_back(8'h00);
	endtask

	// A negative fmt length leaves the fmt chunk out.
	task automatic make_wav(input logic [15:0] fc, input logic [15:0] chans,
			input logic [15:0] bps, input int flen, input logic [31:0] dlen,
			input int dbytes, input bit extras);
		put_tag(wps_pkg::TAG_RIFF);
		put_le($urandom, 4);
		put_tag(wps_pkg::TAG_WAVE);
		if (extras)
			put_junk();
		if (flen >= 0)
			put_fmt(fc, chans, bps, flen);
		put_tag(wps_pkg::TAG_DATA);
		put_le(dlen, 4);
		put_data(dbytes);
		if (extras) begin
			if (dbytes % 2)
				file_q.push_back(8'h00);
			put_junk();
		end
	endtask

	// Queues the first keep bytes of the file (all of it when keep is 0).
	task automatic ship(input int keep);
		int n;
		wav_byte_t it;
		n = (keep > 0 && keep < file_q.size()) ? keep : file_q.size();
		@(negedge clk);
		for (int i = 0; i < n; i++) begin
			it.data = file_q[i];
			it.last = (i == n - 1);
			byte_q.push_back(it);
		end
		bytes_queued += n;
		file_q.delete();
	endtask

	task automatic drain();
		do @(negedge clk);
		while (byte_q.size() != 0 || s_tvalid || frame_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_gain(input logic [15:0] g);
		drain();
		gain_q = g;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_file();
		int roll;
		int flen;
		logic [15:0] chans;
		logic [15:0] fc;
		logic [15:0] bps;
		logic [31:0] dlen;
		roll = $urandom_range(0, 99);
		if (roll >= 90) begin
			repeat ($urandom_range(1, 16)) file_q.push_back(8'($urandom));
			if ($urandom_range(0, 1))
				file_q[0] = 8'h52;
			ship(0);
		end else begin
			chans = 16'($urandom_range(1, 2));
			fc = 16'd1;
			bps = 16'd16;
			flen = $urandom_range(16, 20);
			dlen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(0, 40);
			if (roll >= 72) begin
				case ($urandom_range(0, 4))
					0: fc = $urandom_range(0, 1) ? 16'($urandom) : 16'd3;
					1: bps = $urandom_range(0, 1) ? 16'd8 : 16'($urandom);
					2: chans = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(3, 65535));
					3: flen = -1;
					default: flen = $urandom_range(0, 15);
				endcase
			end
			make_wav(fc, chans, bps, flen, dlen, dlen, $urandom_range(0, 1) == 1);
			ship((roll >= 60 && roll < 72) ? $urandom_range(1, file_q.size()) : 0);
		end
	endtask

	initial begin : stimulus
		logic [15:0] g;
		int start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Broken RIFF tag ending on its fourth byte, broken WAVE tag, one-byte file.
		put_tag(32'h5249_4658);
		ship(0);
		put_tag(wps_pkg::TAG_RIFF);
		put_le(32'd36, 4);
		put_tag(32'h5741_5658);
		put_data(6);
		ship(0);
		file_q.push_back(8'h52);
		ship(0);

		// Each data header check.
		make_wav(16'd1, 16'd1, 16'd16, -1, 32'd4, 0, 1'b0);
		ship(0);
		make_wav(16'd3, 16'd2, 16'd16, 16, 32'd8, 0, 1'b0);
		ship(0);
		make_wav(16'd1, 16'd2, 16'd8, 16, 32'd8, 0, 1'b0);
		ship(0);
		make_wav(16'd1, 16'd0, 16'd16, 16, 32'd8, 0, 1'b0);
		ship(0);
		make_wav(16'd1, 16'd1, 16'd16, 16, 32'd1, 0, 1'b0);
		ship(0);
		make_wav(16'd1, 16'd2, 16'd16, 16, 32'd3, 0, 1'b0);
		ship(0);

		// Back to back with no idling: early ends mid frame and on a frame.
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		make_wav(16'd1, 16'd2, 16'd16, 16, 32'd16, 10, 1'b0);
		ship(0);
		make_wav(16'd1, 16'd2, 16'd16, 16, 32'd16, 8, 1'b0);
		ship(0);

		// The receiver holds off while the sender keeps going. A later fmt overrides,
		// a short one is skipped, a zero-length chunk is passed.
		set_gain(16'hFFFF);
		rx_idle_on = 1'b1;
		hold_ticket++;
		put_tag(wps_pkg::TAG_RIFF);
		put_le($urandom, 4);
		put_tag(wps_pkg::TAG_WAVE);
		put_fmt(16'd1, 16'd2, 16'd8, 16);
		put_fmt(16'd1, 16'd1, 16'd16, 18);
		put_fmt(16'd1, 16'd2, 16'd16, 10);
		put_tag(TAG_LIST);
		put_le(32'd0, 4);
		put_tag(wps_pkg::TAG_DATA);
		put_le(32'd7, 4);
		put_data(7);
		file_q.push_back(8'h00);
		put_junk();
		ship(0);

		// Stereo with an odd data tail and extra chunks around it.
		set_gain(16'h1000);
		tx_idle_on = 1'b1;
		make_wav(16'd1, 16'd2, 16'd16, 16, 32'd13, 13, 1'b1);
		ship(0);

		// Mono with a huge data length that ends early.
		set_gain(16'h0000);
		make_wav(16'd1, 16'd1, 16'd16, 16, 32'hFFFF_FFFF, 6, 1'b0);
		ship(0);

		case ($urandom_range(0, 3))
			0: g = 16'h0001;
			1: g = 16'hFFFF;
			2: g = 16'h1000;
			default: g = 16'($urandom);
		endcase
		set_gain(g);
		start = bytes_queued;
		while (bytes_queued - start < 40)
			random_file();

		drain();
		if (mismatches == 0 && frame_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
